// ===== hw/rtl/jcb_pkg.sv =====
// Shared types and byte codes for the JSON comment blanker.
// Used by jcb_scan, jcb_outq and json_comment_blanker; depends on nothing.
`timescale 1ns / 1ps

package jcb_pkg;

	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_STAR      = 8'h2A;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;

	typedef enum logic [1:0] {
		MODE_NORMAL,
		MODE_STRING,
		MODE_LINE,
		MODE_BLOCK
	} scan_mode_t;

	// One released item
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} res_t;

	// Items handed from the scanner to the output queue in the same cycle
	typedef struct packed {
		logic [1:0] count;
		res_t       r0;
		res_t       r1;
	} push_t;

endpackage

// ===== hw/rtl/jcb_scan.sv =====
// Input register and comment scanner: decides the held byte against the next one.
// Depends on jcb_pkg; feeds jcb_outq through a push_t group.
`timescale 1ns / 1ps

module jcb_scan (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [7:0]    in_byte,
	input  logic          in_last,
	input  logic [1:0]    free,
	output jcb_pkg::push_t push
);
	import jcb_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	scan_mode_t mode_q;
	logic [7:0] held_q;
	logic       held_valid_q;
	logic       pwb_q;
	logic       blank_q;

	scan_mode_t mode_d;
	logic [7:0] v;
	logic       blank_d;
	logic       blank_eff;
	logic [7:0] fb;
	logic [1:0] need_n;
	logic       proc;
	logic       in_acc;

	always_comb begin
		v       = held_q;
		mode_d  = mode_q;
		blank_d = 1'b0;
		if (blank_q) begin
			v = CH_SPACE;
		end else begin
			case (mode_q)
				MODE_LINE: begin
					if (held_q == CH_NEWLINE) mode_d = MODE_NORMAL;
					else v = CH_SPACE;
				end
				MODE_BLOCK: begin
					v = CH_SPACE;
					if (held_q == CH_STAR && byte_s1 == CH_SLASH) begin
						blank_d = 1'b1;
						mode_d  = MODE_NORMAL;
					end
				end
				MODE_STRING: begin
					if (held_q == CH_QUOTE && !pwb_q) mode_d = MODE_NORMAL;
				end
				default: begin
					if (held_q == CH_QUOTE) begin
						mode_d = MODE_STRING;
					end else if (held_q == CH_SLASH) begin
						if (byte_s1 == CH_SLASH) begin
							v       = CH_SPACE;
							blank_d = 1'b1;
							mode_d  = MODE_LINE;
						end else if (byte_s1 == CH_STAR) begin
							v       = CH_SPACE;
							blank_d = 1'b1;
							mode_d  = MODE_BLOCK;
						end
					end
				end
			endcase
		end

		// the final byte blanks only when it completes a two-byte mark begun by the held byte
		blank_eff = held_valid_q ? blank_d : blank_q;
		fb        = blank_eff ? CH_SPACE : byte_s1;
		need_n    = {1'b0, held_valid_q} + {1'b0, last_s1};
		proc      = valid_s1 && (need_n <= free);
		in_stall  = valid_s1 && !proc;
		in_acc    = in_valid && !in_stall;

		push.count = proc ? need_n : 2'd0;
		push.r1    = '{data: fb, last: 1'b1};
		push.r0    = held_valid_q ? res_t'{data: v, last: 1'b0} : push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_NORMAL;
			held_q       <= 8'h00;
			held_valid_q <= 1'b0;
			pwb_q        <= 1'b0;
			blank_q      <= 1'b0;
		end else if (proc) begin
			if (last_s1) begin
				// end of stream: start afresh
				mode_q       <= MODE_NORMAL;
				held_q       <= 8'h00;
				held_valid_q <= 1'b0;
				pwb_q        <= 1'b0;
				blank_q      <= 1'b0;
			end else begin
				if (held_valid_q) begin
					mode_q  <= mode_d;
					blank_q <= blank_d;
					pwb_q   <= (v == CH_BACKSLASH);
				end
				held_q       <= byte_s1;
				held_valid_q <= 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/jcb_outq.sv =====
// Two-entry output queue: takes up to two items a cycle, releases one.
// Depends on jcb_pkg; fed by jcb_scan.
`timescale 1ns / 1ps

module jcb_outq (
	input  logic          clk,
	input  logic          arst_n,
	input  jcb_pkg::push_t push,
	output logic [1:0]    free,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    out_byte,
	output logic          out_last
);
	import jcb_pkg::*;

	logic [1:0] cnt_q;
	res_t       e0_q;
	res_t       e1_q;

	logic       deq;
	logic [1:0] cnt_a;
	logic [1:0] cnt_n;
	res_t       e0_n;
	res_t       e1_n;

	always_comb begin
		deq   = (cnt_q != 2'd0) && !out_stall;
		cnt_a = 2'(cnt_q - {1'b0, deq});
		free  = 2'(2'd2 - cnt_a);
		e0_n  = deq ? e1_q : e0_q;
		e1_n  = e1_q;
		if (push.count != 2'd0) begin
			if (cnt_a == 2'd0) begin
				e0_n = push.r0;
				e1_n = push.r1;
			end else begin
				e1_n = push.r0;
			end
		end
		cnt_n = 2'(cnt_a + push.count);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		e0_q <= e0_n;
		e1_q <= e1_n;
	end

	assign out_valid = (cnt_q != 2'd0);
	assign out_byte  = e0_q.data;
	assign out_last  = e0_q.last;

endmodule

// ===== hw/rtl/json_comment_blanker.sv =====
// Top level of the JSON comment blanker: scanner plus output queue.
// Depends on jcb_pkg, jcb_scan and jcb_outq.
`timescale 1ns / 1ps
//
// Text enters one byte per item on the input channel (in_valid, in_stall,
// in_byte, in_last) and leaves, with the same length, on the output channel
// (out_valid, out_stall, out_byte, out_last). Comment bytes outside strings
// leave as spaces, but a stream's final byte is blanked only when it completes
// a comment mark begun by the held byte. Each byte is held until the next one
// arrives, so an item releases the byte before it; an item with in_last set
// also releases itself and marks it with out_last. An item is registered,
// scanned against the held byte and its results enter a two-entry output
// register queue, from whose head a released byte appears on the output.
// One item is accepted every cycle while out_stall stays low, including
// across the end of a stream; the queue's free space sets the figure when
// a final item yields two results and the receiver holds off.
// While out_stall is high the head item holds; the queue fills and then
// in_stall rises. Reset empties the queue and returns the scanner to plain
// text with nothing held.
//

module json_comment_blanker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_last
);
	import jcb_pkg::*;

	push_t      push;
	logic [1:0] free;

	jcb_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.free     (free),
		.push     (push)
	);

	jcb_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.free      (free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

endmodule
